// File: sv/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int WORD_BITS   = 32;
  localparam int CHAR_BITS   = 6;
  localparam int DIGIT_BITS  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = CHAR_BITS'(45);

  // Number of decimal digits of the widest magnitude
  function automatic int max_digits();
    logic [WORD_BITS-1:0] v;
    int n;
    v = '1;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (v != '0) begin
        v = v / 10;
        n++;
      end
    end
    return n;
  endfunction

  localparam int MAX_DIGITS = max_digits();
  localparam int IDX_BITS   = $clog2(MAX_DIGITS);

  // ceil(2^(W+3) / 10): exact divide-by-ten reciprocal for W-bit operands
  localparam logic [WORD_BITS+4:0] RECIP_FULL =
      (((WORD_BITS+5)'(1) << (WORD_BITS + 3)) + (WORD_BITS+5)'(9)) / (WORD_BITS+5)'(10);
  localparam logic [WORD_BITS-1:0] RECIP = RECIP_FULL[WORD_BITS-1:0];

  typedef struct packed {
    logic                 negative;
    logic [WORD_BITS-1:0] mag;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// File: sv/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels for input words and output characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface itoa_in_if;
  import itoa_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itoa_out_if;
  import itoa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] text_char;
  logic                 last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

// File: sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed word to its decimal ASCII text, sign first, MSB first.
// ----------------------------------------------------------------------------
// The first character follows the queue, the single divide-by-ten unit's loop over
// every digit and the output register. The back end takes a new word only once the
// last character of the word before is registered; one char per cycle while ready.
// Input side decoupled by a 2-entry queue; output through a register.
// Reset: synchronous, active low; clears control state only, no clear sweep.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);
  import itoa_pkg::*;

  logic  queue_full;
  logic  push;
  item_t push_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  itoa_front u_front (
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  itoa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  itoa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: sv/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input words, splits off the sign and forms the unsigned magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_front (
  itoa_in_if.sink         in_ch,
  input  wire logic       queue_full,
  output logic            push,
  output itoa_pkg::item_t push_item
);
  import itoa_pkg::*;

  logic [WORD_BITS-1:0] word_w;
  logic                 neg_w;

  assign word_w = WORD_BITS'(in_ch.value);
  assign neg_w  = word_w[WORD_BITS-1];

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;

  always_comb begin
    push_item.negative = neg_w;
    push_item.mag      = neg_w ? (~word_w + 1'b1) : word_w;
  end

endmodule

`default_nettype wire

// File: sv/itoa_queue.sv
// ----------------------------------------------------------------------------
// itoa_queue
// Short FIFO between the classifying front and the conversion back end.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire itoa_pkg::item_t  push_item,
  output logic                  full,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output itoa_pkg::item_t       pop_item
);
  import itoa_pkg::*;

  item_t                entries_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 pop;

  assign full      = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

// File: sv/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// Divide-by-ten digit extraction, then sign and digits out MSB first
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire itoa_pkg::item_t  q_item,
  itoa_out_if.source            out_ch
);
  import itoa_pkg::*;

  bk_state_t              state_r, state_nxt;
  logic [WORD_BITS-1:0]   mag_r;
  logic                   neg_r;
  logic [IDX_BITS-1:0]    k_r;
  logic [DIGIT_BITS-1:0]  digits_r [MAX_DIGITS];

  logic                   out_valid_r;
  logic [CHAR_BITS-1:0]   out_char_r;
  logic                   out_last_r;

  logic [2*WORD_BITS-1:0] prod_w;
  logic [WORD_BITS-1:0]   quot_w;
  logic [WORD_BITS-1:0]   diff_w;
  logic [DIGIT_BITS-1:0]  rem_w;

  logic                   out_free;
  logic                   emit;
  logic [CHAR_BITS-1:0]   emit_char;
  logic                   emit_last;
  logic                   take;

  // one divide-by-ten step per cycle
  assign prod_w = mag_r * RECIP;
  assign quot_w = WORD_BITS'(prod_w >> (WORD_BITS + 3));
  assign diff_w = mag_r - ((quot_w << 3) + (quot_w << 1));
  assign rem_w  = diff_w[DIGIT_BITS-1:0];

  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = q_valid && q_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (quot_w == '0) begin
          state_nxt = neg_r ? BK_SIGN : BK_EMIT;
        end
      end
      BK_SIGN: begin
        if (out_free) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && k_r == '0) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    unique case (state_r)
      BK_IDLE: q_ready = 1'b1;
      BK_DIV:  ;
      BK_SIGN: begin
        emit      = out_free;
        emit_char = CHAR_MINUS;
      end
      BK_EMIT: begin
        emit      = out_free;
        emit_char = CHAR_ZERO + CHAR_BITS'(digits_r[k_r]);
        emit_last = (k_r == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
    if (take) begin
      mag_r <= q_item.mag;
      neg_r <= q_item.negative;
      k_r   <= '0;
    end else if (state_r == BK_DIV) begin
      digits_r[k_r] <= rem_w;
      mag_r         <= quot_w;
      if (quot_w != '0) begin
        k_r <= k_r + 1'b1;
      end
    end else if (state_r == BK_EMIT && out_free && k_r != '0) begin
      k_r <= k_r - 1'b1;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_char = out_char_r;
  assign out_ch.last_char = out_last_r;

  a_sign_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SIGN) |-> neg_r)
    else $error("sign state for non-negative value");

  a_take_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r == BK_DIV))
    else $error("accepted item did not start division");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (k_r <= IDX_BITS'(MAX_DIGITS - 1)))
    else $error("digit index out of range");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == BK_IDLE))
    else $error("last character did not end the item");

endmodule

`default_nettype wire
